### rtl/prpi_pkg.sv
package prpi_pkg;

  // Default sizes of the edge store and the node tables.
  localparam int MAX_NODES_DEF = 1024;
  localparam int MAX_EDGES_DEF = 8192;

  // Field widths.
  localparam int NODE_W  = 10;
  localparam int NCFG_W  = 11;
  localparam int ITER_W  = 16;
  localparam int DAMP_W  = 17;
  localparam int TOL_W   = 32;
  localparam int RANK_W  = 33;
  localparam int CHG_W   = 34;
  localparam int CFGD_W  = 32;
  localparam int CFGI_W  = 2;

  // Request codes.
  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_RUN  = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_RANGE  = 2'd2;
  localparam logic [1:0] ST_NO_RUN = 2'd3;

  // Configuration register indexes.
  localparam logic [CFGI_W-1:0] CFG_NODE_COUNT = 2'd0;
  localparam logic [CFGI_W-1:0] CFG_MAX_ITER   = 2'd1;
  localparam logic [CFGI_W-1:0] CFG_DAMPING    = 2'd2;
  localparam logic [CFGI_W-1:0] CFG_TOLERANCE  = 2'd3;

  // Configuration reset values.
  localparam logic [NCFG_W-1:0] NODE_COUNT_RST = 11'd1;
  localparam logic [ITER_W-1:0] MAX_ITER_RST   = 16'd100;
  localparam logic [DAMP_W-1:0] DAMPING_RST    = 17'd55706;
  localparam logic [TOL_W-1:0]  TOLERANCE_RST  = 32'd43;

  // Fixed-point constants.
  localparam logic [DAMP_W-1:0] DAMP_ONE = 17'd65536;
  localparam logic [RANK_W-1:0] RANK_ONE = 33'h1_0000_0000;
  localparam logic [CHG_W-1:0]  SUM_CAP  = 34'h2_0000_0000;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [NODE_W-1:0] from_node;
    logic [NODE_W-1:0] to_node;
    logic [NODE_W-1:0] query_node;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [RANK_W-1:0] rank_value;
    logic [ITER_W-1:0] iterations_used;
    logic [CHG_W-1:0]  last_change;
    logic              converged;
  } out_item_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_INIT_WAIT,
    S_INIT_WR,
    S_NODE_RD,
    S_NODE_CHK,
    S_NODE_DIV,
    S_BASE_WAIT1,
    S_BASE_WAIT2,
    S_BASE_SUM,
    S_EDGE_RD,
    S_EDGE_CHK,
    S_EDGE_WR,
    S_FIN_RD,
    S_FIN_MUL,
    S_FIN_WR,
    S_ITER_END,
    S_DONE
  } state_e;

endpackage

### rtl/pagerank_power_iteration_core.sv
// Channel   Handshake                     Payload
// ------    ---------------------------   ---------------------------------
// in        in_valid_i / in_ready_o       in_item_i   (prpi_pkg::in_item_t)
// out       out_valid_o / out_ready_i     out_item_o  (prpi_pkg::out_item_t)
// cfg       cfg_valid_i / cfg_ready_o     cfg_index_i, cfg_data_i
//
// Load and read items are taken one per cycle while the core is idle and the
// read stage is empty or can move on; each result passes through a read stage
// and then an output register. A run first divides to set the initial rank of
// one over n and writes it to each of the n nodes; each iteration then makes a
// node pass with a serial divide of 44 quotient bits for every node that has
// out-edges, two base divides, a walk over the E stored edges and a final pass.
// After reset all MAX_NODES entries of the out-degree memory are cleared before
// the first item is taken; configuration writes are taken at all times.
module pagerank_power_iteration_core
  import prpi_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEF,
  parameter int MAX_EDGES = MAX_EDGES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_item_t          in_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_item_t         out_item_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CFGI_W-1:0] cfg_index_i,
  input  logic [CFGD_W-1:0] cfg_data_i
);

  localparam int NIDX_W = $clog2(MAX_NODES);
  localparam int EIDX_W = $clog2(MAX_EDGES);
  localparam int ECNT_W = $clog2(MAX_EDGES + 1);
  localparam int DEG_W  = ECNT_W;
  localparam int EDGE_W = 2 * NODE_W;
  localparam int DANG_W = RANK_W + NCFG_W;
  localparam int DIV_W  = DANG_W;
  localparam int DVS_W  = (DEG_W > NCFG_W) ? DEG_W : NCFG_W;
  localparam int DCNT_W = $clog2(DIV_W + 1);
  localparam int PROD_W = DAMP_W + CHG_W;

  // Configuration registers.
  logic [NCFG_W-1:0] cfg_nodes_q;
  logic [ITER_W-1:0] cfg_iter_q;
  logic [DAMP_W-1:0] cfg_damp_q;
  logic [TOL_W-1:0]  cfg_tol_q;

  // Memories and their ports.
  logic [EDGE_W-1:0] edge_mem [MAX_EDGES];
  logic [DEG_W-1:0]  deg_mem  [MAX_NODES];
  logic [RANK_W-1:0] rank_mem [MAX_NODES];
  logic [CHG_W-1:0]  next_mem [MAX_NODES];
  logic [RANK_W-1:0] ctb_mem  [MAX_NODES];

  logic              edge_we, edge_re;
  logic [EIDX_W-1:0] edge_waddr, edge_raddr;
  logic [EDGE_W-1:0] edge_wdata, edge_rd_q;
  logic              deg_we, deg_re;
  logic [NIDX_W-1:0] deg_waddr, deg_raddr;
  logic [DEG_W-1:0]  deg_wdata, deg_rd_q;
  logic              rank_we, rank_re;
  logic [NIDX_W-1:0] rank_waddr, rank_raddr;
  logic [RANK_W-1:0] rank_wdata, rank_rd_q;
  logic              next_we, next_re;
  logic [NIDX_W-1:0] next_waddr, next_raddr;
  logic [CHG_W-1:0]  next_wdata, next_rd_q;
  logic              ctb_we, ctb_re;
  logic [NIDX_W-1:0] ctb_waddr, ctb_raddr;
  logic [RANK_W-1:0] ctb_wdata, ctb_rd_q;

  // Control and datapath registers.
  state_e            state_q, state_d;
  logic [NIDX_W-1:0] clr_q, clr_d;
  logic [NCFG_W-1:0] node_q, node_d;
  logic [ECNT_W-1:0] edge_q, edge_d;
  logic [ITER_W-1:0] iter_q, iter_d;
  logic [DANG_W-1:0] dang_q, dang_d;
  logic [RANK_W-1:0] base1_q, base1_d;
  logic [CHG_W-1:0]  base_q, base_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [CHG_W-1:0]  chg_q, chg_d;
  logic [ITER_W-1:0] sum_iter_q, sum_iter_d;
  logic [CHG_W-1:0]  sum_chg_q, sum_chg_d;
  logic              sum_conv_q, sum_conv_d;
  logic              run_done_q, run_done_d;
  logic [ECNT_W-1:0] edge_total_q, edge_total_d;

  // Out-degree update pipeline and forwarding register.
  logic              ld_pend_q, ld_pend_d;
  logic [NIDX_W-1:0] ld_addr_q, ld_addr_d;
  logic              fwd_vld_q;
  logic [NIDX_W-1:0] fwd_addr_q;
  logic [DEG_W-1:0]  fwd_val_q;

  // Read stage and output register.
  logic              s1_valid_q, s1_valid_d;
  logic [1:0]        s1_status_q, s1_status_d;
  logic              s1_rd_q, s1_rd_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_item_q, out_item_d;

  // Serial divider.
  logic              div_start;
  logic [DIV_W-1:0]  div_dvd;
  logic [DVS_W-1:0]  div_dvs;
  logic [DVS_W:0]    div_rem_q;
  logic [DIV_W-1:0]  div_quo_q;
  logic [DVS_W-1:0]  div_dvs_q;
  logic [DCNT_W-1:0] div_cnt_q;
  logic              div_busy;
  logic [DVS_W:0]    div_rem_sh;
  logic              div_ge;

  // Combinational helpers.
  logic [NCFG_W-1:0] n_eff;
  logic [DAMP_W-1:0] d_eff;
  logic              out_free, s1_adv, in_acc;
  logic [NODE_W-1:0] e_src, e_dst;
  logic [CHG_W:0]    e_sum;
  logic [CHG_W+1:0]  f_val;
  logic [RANK_W-1:0] f_new;
  logic [RANK_W-1:0] f_diff;
  logic [CHG_W:0]    f_chg;
  logic [DEG_W-1:0]  deg_cur;
  logic              last_node;

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Effective node count and damping.
  always_comb begin
    if (cfg_nodes_q == '0) begin
      n_eff = NCFG_W'(1);
    end else if (32'(cfg_nodes_q) > MAX_NODES) begin
      n_eff = NCFG_W'(MAX_NODES);
    end else begin
      n_eff = cfg_nodes_q;
    end
    d_eff = (cfg_damp_q > DAMP_ONE) ? DAMP_ONE : cfg_damp_q;
  end

  // Handshake bookkeeping.
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_ready_o = (state_q == S_IDLE) && (!s1_valid_q || out_free);
  assign in_acc     = in_valid_i && in_ready_o;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_nodes_q <= NODE_COUNT_RST;
      cfg_iter_q  <= MAX_ITER_RST;
      cfg_damp_q  <= DAMPING_RST;
      cfg_tol_q   <= TOLERANCE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_NODE_COUNT: cfg_nodes_q <= cfg_data_i[NCFG_W-1:0];
        CFG_MAX_ITER:   cfg_iter_q  <= cfg_data_i[ITER_W-1:0];
        CFG_DAMPING:    cfg_damp_q  <= cfg_data_i[DAMP_W-1:0];
        CFG_TOLERANCE:  cfg_tol_q   <= cfg_data_i[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // Serial restoring divider, one quotient bit per cycle.
  assign div_busy   = (div_cnt_q != '0);
  assign div_rem_sh = {div_rem_q[DVS_W-1:0], div_quo_q[DIV_W-1]};
  assign div_ge     = (div_rem_sh >= {1'b0, div_dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (div_start) begin
      div_cnt_q <= DCNT_W'(DIV_W);
    end else if (div_busy) begin
      div_cnt_q <= div_cnt_q - DCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      div_rem_q <= '0;
      div_quo_q <= div_dvd;
      div_dvs_q <= div_dvs;
    end else if (div_busy) begin
      div_rem_q <= div_ge ? (div_rem_sh - {1'b0, div_dvs_q}) : div_rem_sh;
      div_quo_q <= {div_quo_q[DIV_W-2:0], div_ge};
    end
  end

  // Edge fields and arithmetic of the edge and final passes.
  assign e_src    = edge_rd_q[EDGE_W-1:NODE_W];
  assign e_dst    = edge_rd_q[NODE_W-1:0];
  assign e_sum    = {1'b0, next_rd_q} + (CHG_W + 1)'(ctb_rd_q);
  assign f_val    = (CHG_W + 2)'(base_q) + (CHG_W + 2)'(prod_q >> 16);
  assign f_new    = (f_val > (CHG_W + 2)'(RANK_ONE)) ? RANK_ONE : f_val[RANK_W-1:0];
  assign f_diff   = (f_new > rank_rd_q) ? (f_new - rank_rd_q) : (rank_rd_q - f_new);
  assign f_chg    = {1'b0, chg_q} + (CHG_W + 1)'(f_diff);
  assign deg_cur  = (fwd_vld_q && fwd_addr_q == ld_addr_q) ? fwd_val_q : deg_rd_q;
  assign last_node = (node_q == n_eff - NCFG_W'(1));

  // Sequencer, item path and memory port control.
  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    node_d       = node_q;
    edge_d       = edge_q;
    iter_d       = iter_q;
    dang_d       = dang_q;
    base1_d      = base1_q;
    base_d       = base_q;
    prod_d       = prod_q;
    chg_d        = chg_q;
    sum_iter_d   = sum_iter_q;
    sum_chg_d    = sum_chg_q;
    sum_conv_d   = sum_conv_q;
    run_done_d   = run_done_q;
    edge_total_d = edge_total_q;
    ld_pend_d    = 1'b0;
    ld_addr_d    = ld_addr_q;
    s1_valid_d   = s1_valid_q;
    s1_status_d  = s1_status_q;
    s1_rd_d      = s1_rd_q;
    out_valid_d  = out_valid_q;
    out_item_d   = out_item_q;

    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;

    edge_we = 1'b0; edge_waddr = '0; edge_wdata = '0;
    edge_re = 1'b0; edge_raddr = '0;
    deg_we  = 1'b0; deg_waddr  = '0; deg_wdata  = '0;
    deg_re  = 1'b0; deg_raddr  = '0;
    rank_we = 1'b0; rank_waddr = '0; rank_wdata = '0;
    rank_re = 1'b0; rank_raddr = '0;
    next_we = 1'b0; next_waddr = '0; next_wdata = '0;
    next_re = 1'b0; next_raddr = '0;
    ctb_we  = 1'b0; ctb_waddr  = '0; ctb_wdata  = '0;
    ctb_re  = 1'b0; ctb_raddr  = '0;

    // Output register drains and takes the read stage.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (s1_adv) begin
      out_valid_d                = 1'b1;
      out_item_d.status          = s1_status_q;
      out_item_d.rank_value      = s1_rd_q ? rank_rd_q : '0;
      out_item_d.iterations_used = sum_iter_q;
      out_item_d.last_change     = sum_chg_q;
      out_item_d.converged       = sum_conv_q;
      s1_valid_d                 = 1'b0;
    end

    // Second half of an out-degree increment.
    if (ld_pend_q) begin
      deg_we    = 1'b1;
      deg_waddr = ld_addr_q;
      deg_wdata = deg_cur + DEG_W'(1);
    end

    case (state_q)
      // Clear the out-degree memory after reset.
      S_CLEAR: begin
        deg_we    = 1'b1;
        deg_waddr = clr_q;
        deg_wdata = '0;
        clr_d     = clr_q + NIDX_W'(1);
        if (clr_q == NIDX_W'(MAX_NODES - 1)) begin
          state_d = S_IDLE;
        end
      end

      // Take load, read and run items.
      S_IDLE: begin
        if (in_acc) begin
          if (in_item_i.req_type == REQ_RUN) begin
            div_start  = 1'b1;
            div_dvd    = DIV_W'(RANK_ONE);
            div_dvs    = DVS_W'(n_eff);
            node_d     = '0;
            sum_iter_d = '0;
            sum_chg_d  = '0;
            sum_conv_d = 1'b0;
            state_d    = S_INIT_WAIT;
          end else begin
            s1_valid_d  = 1'b1;
            s1_status_d = ST_OK;
            s1_rd_d     = 1'b0;
            if (in_item_i.req_type == REQ_LOAD) begin
              if (edge_total_q >= ECNT_W'(MAX_EDGES)) begin
                s1_status_d = ST_FULL;
              end else if ({1'b0, in_item_i.from_node} >= n_eff ||
                           {1'b0, in_item_i.to_node} >= n_eff) begin
                s1_status_d = ST_RANGE;
              end else begin
                edge_we      = 1'b1;
                edge_waddr   = edge_total_q[EIDX_W-1:0];
                edge_wdata   = {in_item_i.from_node, in_item_i.to_node};
                edge_total_d = edge_total_q + ECNT_W'(1);
                deg_re       = 1'b1;
                deg_raddr    = NIDX_W'(in_item_i.from_node);
                ld_pend_d    = 1'b1;
                ld_addr_d    = NIDX_W'(in_item_i.from_node);
              end
            end else if (in_item_i.req_type == REQ_READ) begin
              if (!run_done_q) begin
                s1_status_d = ST_NO_RUN;
              end else if ({1'b0, in_item_i.query_node} >= n_eff) begin
                s1_status_d = ST_RANGE;
              end else begin
                rank_re    = 1'b1;
                rank_raddr = NIDX_W'(in_item_i.query_node);
                s1_rd_d    = 1'b1;
              end
            end
          end
        end
      end

      // Initial rank is one over n.
      S_INIT_WAIT: begin
        if (!div_busy) begin
          state_d = S_INIT_WR;
        end
      end

      S_INIT_WR: begin
        rank_we    = 1'b1;
        rank_waddr = NIDX_W'(node_q);
        rank_wdata = div_quo_q[RANK_W-1:0];
        node_d     = node_q + NCFG_W'(1);
        if (last_node) begin
          node_d = '0;
          iter_d = ITER_W'(1);
          dang_d = '0;
          state_d = (cfg_iter_q == '0) ? S_DONE : S_NODE_RD;
        end
      end

      // Node pass: dangling sum, per-node contribution, clear accumulators.
      S_NODE_RD: begin
        rank_re    = 1'b1;
        rank_raddr = NIDX_W'(node_q);
        deg_re     = 1'b1;
        deg_raddr  = NIDX_W'(node_q);
        state_d    = S_NODE_CHK;
      end

      S_NODE_CHK: begin
        next_we    = 1'b1;
        next_waddr = NIDX_W'(node_q);
        next_wdata = '0;
        if (deg_rd_q == '0) begin
          dang_d    = dang_q + DANG_W'(rank_rd_q);
          ctb_we    = 1'b1;
          ctb_waddr = NIDX_W'(node_q);
          ctb_wdata = '0;
          node_d    = node_q + NCFG_W'(1);
          state_d   = S_NODE_RD;
          if (last_node) begin
            div_start = 1'b1;
            div_dvd   = DIV_W'({DAMP_ONE - d_eff, 16'd0});
            div_dvs   = DVS_W'(n_eff);
            state_d   = S_BASE_WAIT1;
          end
        end else begin
          div_start = 1'b1;
          div_dvd   = DIV_W'(rank_rd_q);
          div_dvs   = DVS_W'(deg_rd_q);
          state_d   = S_NODE_DIV;
        end
      end

      S_NODE_DIV: begin
        if (!div_busy) begin
          ctb_we    = 1'b1;
          ctb_waddr = NIDX_W'(node_q);
          ctb_wdata = div_quo_q[RANK_W-1:0];
          node_d    = node_q + NCFG_W'(1);
          state_d   = S_NODE_RD;
          if (last_node) begin
            div_start = 1'b1;
            div_dvd   = DIV_W'({DAMP_ONE - d_eff, 16'd0});
            div_dvs   = DVS_W'(n_eff);
            state_d   = S_BASE_WAIT1;
          end
        end
      end

      // Base term: (1-d)/n + d*(dangling/n).
      S_BASE_WAIT1: begin
        if (!div_busy) begin
          base1_d   = div_quo_q[RANK_W-1:0];
          div_start = 1'b1;
          div_dvd   = dang_q;
          div_dvs   = DVS_W'(n_eff);
          state_d   = S_BASE_WAIT2;
        end
      end

      S_BASE_WAIT2: begin
        if (!div_busy) begin
          prod_d  = PROD_W'(d_eff) * PROD_W'(div_quo_q[RANK_W-1:0]);
          state_d = S_BASE_SUM;
        end
      end

      S_BASE_SUM: begin
        base_d  = CHG_W'(base1_q) + CHG_W'(prod_q >> 16);
        edge_d  = '0;
        state_d = S_EDGE_RD;
      end

      // Edge pass: accumulate contributions into the destination.
      S_EDGE_RD: begin
        if (edge_q == edge_total_q) begin
          node_d  = '0;
          chg_d   = '0;
          state_d = S_FIN_RD;
        end else begin
          edge_re    = 1'b1;
          edge_raddr = edge_q[EIDX_W-1:0];
          state_d    = S_EDGE_CHK;
        end
      end

      S_EDGE_CHK: begin
        if ({1'b0, e_src} < n_eff && {1'b0, e_dst} < n_eff) begin
          ctb_re     = 1'b1;
          ctb_raddr  = NIDX_W'(e_src);
          next_re    = 1'b1;
          next_raddr = NIDX_W'(e_dst);
          state_d    = S_EDGE_WR;
        end else begin
          edge_d  = edge_q + ECNT_W'(1);
          state_d = S_EDGE_RD;
        end
      end

      S_EDGE_WR: begin
        next_we    = 1'b1;
        next_waddr = NIDX_W'(e_dst);
        next_wdata = (e_sum > (CHG_W + 1)'(SUM_CAP)) ? SUM_CAP : e_sum[CHG_W-1:0];
        edge_d     = edge_q + ECNT_W'(1);
        state_d    = S_EDGE_RD;
      end

      // Final pass: new rank, saturate, accumulate the L1 change.
      S_FIN_RD: begin
        next_re    = 1'b1;
        next_raddr = NIDX_W'(node_q);
        rank_re    = 1'b1;
        rank_raddr = NIDX_W'(node_q);
        state_d    = S_FIN_MUL;
      end

      S_FIN_MUL: begin
        prod_d  = PROD_W'(d_eff) * PROD_W'(next_rd_q);
        state_d = S_FIN_WR;
      end

      S_FIN_WR: begin
        rank_we    = 1'b1;
        rank_waddr = NIDX_W'(node_q);
        rank_wdata = f_new;
        chg_d      = (f_chg > (CHG_W + 1)'(SUM_CAP)) ? SUM_CAP : f_chg[CHG_W-1:0];
        node_d     = node_q + NCFG_W'(1);
        state_d    = last_node ? S_ITER_END : S_FIN_RD;
      end

      // Stop test after each iteration.
      S_ITER_END: begin
        sum_iter_d = iter_q;
        sum_chg_d  = chg_q;
        if (chg_q < CHG_W'(cfg_tol_q)) begin
          sum_conv_d = 1'b1;
          state_d    = S_DONE;
        end else if (iter_q == cfg_iter_q) begin
          state_d = S_DONE;
        end else begin
          iter_d  = iter_q + ITER_W'(1);
          node_d  = '0;
          dang_d  = '0;
          state_d = S_NODE_RD;
        end
      end

      // Hand out the result of the run.
      S_DONE: begin
        if (!s1_valid_q && out_free) begin
          out_valid_d                = 1'b1;
          out_item_d.status          = ST_OK;
          out_item_d.rank_value      = '0;
          out_item_d.iterations_used = sum_iter_q;
          out_item_d.last_change     = sum_chg_q;
          out_item_d.converged       = sum_conv_q;
          run_done_d                 = 1'b1;
          state_d                    = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      node_q       <= '0;
      edge_q       <= '0;
      iter_q       <= '0;
      sum_iter_q   <= '0;
      sum_chg_q    <= '0;
      sum_conv_q   <= 1'b0;
      run_done_q   <= 1'b0;
      edge_total_q <= '0;
      ld_pend_q    <= 1'b0;
      fwd_vld_q    <= 1'b0;
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      node_q       <= node_d;
      edge_q       <= edge_d;
      iter_q       <= iter_d;
      sum_iter_q   <= sum_iter_d;
      sum_chg_q    <= sum_chg_d;
      sum_conv_q   <= sum_conv_d;
      run_done_q   <= run_done_d;
      edge_total_q <= edge_total_d;
      ld_pend_q    <= ld_pend_d;
      s1_valid_q   <= s1_valid_d;
      out_valid_q  <= out_valid_d;
      if (ld_pend_q) begin
        fwd_vld_q <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    dang_q      <= dang_d;
    base1_q     <= base1_d;
    base_q      <= base_d;
    prod_q      <= prod_d;
    chg_q       <= chg_d;
    ld_addr_q   <= ld_addr_d;
    s1_status_q <= s1_status_d;
    s1_rd_q     <= s1_rd_d;
    out_item_q  <= out_item_d;
    if (ld_pend_q) begin
      fwd_addr_q <= ld_addr_q;
      fwd_val_q  <= deg_wdata;
    end
  end

  // Edge store.
  always_ff @(posedge clk_i) begin
    if (edge_we) begin
      edge_mem[edge_waddr] <= edge_wdata;
    end
    if (edge_re) begin
      edge_rd_q <= edge_mem[edge_raddr];
    end
  end

  // Out-degree memory.
  always_ff @(posedge clk_i) begin
    if (deg_we) begin
      deg_mem[deg_waddr] <= deg_wdata;
    end
    if (deg_re) begin
      deg_rd_q <= deg_mem[deg_raddr];
    end
  end

  // Rank memory.
  always_ff @(posedge clk_i) begin
    if (rank_we) begin
      rank_mem[rank_waddr] <= rank_wdata;
    end
    if (rank_re) begin
      rank_rd_q <= rank_mem[rank_raddr];
    end
  end

  // Incoming-sum accumulators.
  always_ff @(posedge clk_i) begin
    if (next_we) begin
      next_mem[next_waddr] <= next_wdata;
    end
    if (next_re) begin
      next_rd_q <= next_mem[next_raddr];
    end
  end

  // Per-node contribution, rank over out-degree.
  always_ff @(posedge clk_i) begin
    if (ctb_we) begin
      ctb_mem[ctb_waddr] <= ctb_wdata;
    end
    if (ctb_re) begin
      ctb_rd_q <= ctb_mem[ctb_raddr];
    end
  end

endmodule
